@@ sv/msss_pkg.sv @@
// Package for the magnitude rise sorted store.
// Holds the default sizes, the transaction mode codes, the cell operation codes
// and the control state encoding. No dependencies.
package msss_pkg;

    // Default sizes handed to the top level parameters.
    localparam int CAPACITY_DEF    = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    // Mode codes carried by an input transaction.
    typedef enum logic [1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_CLEAR  = 2'd1,
        MODE_READ   = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    // Operation broadcast to every cell of the row in a cycle.
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_ROTATE = 2'd2
    } t_cell_op;

    // Control state, one-hot.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } t_state;

endpackage

@@ sv/msss_chan_if.sv @@
// Channel interfaces of the magnitude rise sorted store.
// Each carries valid, ready and the payload; depends on msss_pkg for defaults.
interface msss_in_if import msss_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    mode;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output mode, output sample, input ready);
    modport sink   (input valid, input mode, input sample, output ready);
endinterface

interface msss_out_if import msss_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = $clog2(CAPACITY_DEF + 1)
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] entry_value;
    logic                          entry_valid;
    logic                          accepted;
    logic                          overflow;
    logic [COUNT_BITS-1:0]         entry_count;
    logic signed [SAMPLE_BITS-1:0] minimum;
    logic                          last;

    modport source (output valid, output entry_value, output entry_valid,
                    output accepted, output overflow, output entry_count,
                    output minimum, output last, input ready);
    modport sink   (input valid, input entry_value, input entry_valid,
                    input accepted, input overflow, input entry_count,
                    input minimum, input last, output ready);
endinterface

@@ sv/magnitude_rise_sorted_store_core.sv @@
// Magnitude rise sorted store. A sample transaction whose magnitude strictly
// exceeds that of the previous sample is inserted, in ascending order, into a row
// of CAPACITY cells while one is free; every cell compares against the broadcast
// sample and shifts up in the same cycle, so a sample, clear or unused-mode
// transaction may be accepted every cycle while the result register drains.
// A readout transaction yields one result per stored entry (or a single invalid
// result when empty) and holds off the input meanwhile: the row rotates one
// place towards its head per result through the single output register, and after
// the last entry the row is back in its original order. There is no clearing pass.
// Depends on msss_pkg, msss_chan_if and msss_cell.
module magnitude_rise_sorted_store_core import msss_pkg::*; #(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    msss_in_if.sink    i_in,
    msss_out_if.source o_out
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic signed [SAMPLE_BITS-1:0] MIN_EMPTY = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    // Control and scalar state.
    t_state                        r_state, n_state;
    logic [CNT_W-1:0]              r_count, n_count;
    logic [CNT_W-1:0]              r_left, n_left;
    logic signed [SAMPLE_BITS-1:0] r_min, n_min;
    logic [SAMPLE_BITS-1:0]        r_prev, n_prev;
    logic                          r_have_prev, n_have_prev;

    // Result register.
    logic                          r_ovalid;
    logic signed [SAMPLE_BITS-1:0] r_oentry_value, n_oentry_value;
    logic                          r_oentry_valid, n_oentry_valid;
    logic                          r_oaccepted, n_oaccepted;
    logic                          r_ooverflow, n_ooverflow;
    logic [CNT_W-1:0]              r_ocount, n_ocount;
    logic signed [SAMPLE_BITS-1:0] r_omin, n_omin;
    logic                          r_olast, n_olast;

    logic                          w_slot_free;
    logic                          w_accept;
    logic                          w_produce;
    t_cell_op                      w_op;
    logic [SAMPLE_BITS-1:0]        w_mag;
    logic signed [SAMPLE_BITS-1:0] w_value [CAPACITY];
    logic                          w_ge    [CAPACITY];

    assign w_slot_free = !r_ovalid || o_out.ready;
    assign i_in.ready  = (r_state == ST_IDLE) && w_slot_free;
    assign w_accept    = i_in.valid && i_in.ready;

    // Unsigned magnitude; the most negative value keeps its full size.
    assign w_mag = i_in.sample[SAMPLE_BITS-1] ? (~i_in.sample + 1'b1) : i_in.sample;

    // Row of cells.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [SAMPLE_BITS-1:0] w_left_value;
        logic                          w_left_ge;
        logic signed [SAMPLE_BITS-1:0] w_right_value;

        if (g == 0) begin : g_first
            assign w_left_value = i_in.sample;
            assign w_left_ge    = 1'b0;
        end else begin : g_inner
            assign w_left_value = w_value[g-1];
            assign w_left_ge    = w_ge[g-1];
        end

        if (g == CAPACITY - 1) begin : g_end
            assign w_right_value = w_value[0];
        end else begin : g_mid
            assign w_right_value = w_value[g+1];
        end

        msss_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .CNT_W       (CNT_W),
            .IDX         (g)
        ) u_cell (
            .i_clk         (i_clk),
            .i_op          (w_op),
            .i_count       (r_count),
            .i_sample      (i_in.sample),
            .i_left_value  (w_left_value),
            .i_left_ge     (w_left_ge),
            .i_right_value (w_right_value),
            .i_head_value  (w_value[0]),
            .o_value       (w_value[g]),
            .o_ge          (w_ge[g])
        );
    end

    // Transaction decoding and result formation.
    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_left         = r_left;
        n_min          = r_min;
        n_prev         = r_prev;
        n_have_prev    = r_have_prev;
        w_op           = CELL_HOLD;
        w_produce      = 1'b0;
        n_oentry_value = '0;
        n_oentry_valid = 1'b0;
        n_oaccepted    = 1'b0;
        n_ooverflow    = 1'b0;
        n_ocount       = r_count;
        n_omin         = (r_count == '0) ? '0 : r_min;
        n_olast        = 1'b1;

        if (w_accept) begin
            w_produce = 1'b1;
            case (t_mode'(i_in.mode))
                MODE_SAMPLE: begin
                    if (r_have_prev && (w_mag > r_prev)) begin
                        if (r_count < CNT_W'(CAPACITY)) begin
                            w_op        = CELL_INSERT;
                            n_count     = r_count + 1'b1;
                            n_oaccepted = 1'b1;
                            if (i_in.sample < r_min) begin
                                n_min = i_in.sample;
                            end
                        end else begin
                            n_ooverflow = 1'b1;
                        end
                    end
                    n_prev      = w_mag;
                    n_have_prev = 1'b1;
                    n_ocount    = n_count;
                    n_omin      = (n_count == '0) ? '0 : n_min;
                end
                MODE_CLEAR: begin
                    n_count     = '0;
                    n_min       = MIN_EMPTY;
                    n_prev      = '0;
                    n_have_prev = 1'b0;
                    n_ocount    = '0;
                    n_omin      = '0;
                end
                MODE_READ: begin
                    if (r_count != '0) begin
                        w_op           = CELL_ROTATE;
                        n_oentry_value = w_value[0];
                        n_oentry_valid = 1'b1;
                        n_olast        = r_count == CNT_W'(1);
                        if (r_count != CNT_W'(1)) begin
                            n_state = ST_READ;
                            n_left  = r_count - 1'b1;
                        end
                    end
                end
                default: begin
                    n_state = r_state;
                end
            endcase
        end else if ((r_state == ST_READ) && w_slot_free) begin
            // Remaining entries of a readout, one per free result slot.
            w_produce      = 1'b1;
            w_op           = CELL_ROTATE;
            n_oentry_value = w_value[0];
            n_oentry_valid = 1'b1;
            n_olast        = r_left == CNT_W'(1);
            n_left         = r_left - 1'b1;
            if (r_left == CNT_W'(1)) begin
                n_state = ST_IDLE;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_min       <= MIN_EMPTY;
            r_prev      <= '0;
            r_have_prev <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_left      <= n_left;
            r_min       <= n_min;
            r_prev      <= n_prev;
            r_have_prev <= n_have_prev;
            if (w_produce) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (w_produce) begin
            r_oentry_value <= n_oentry_value;
            r_oentry_valid <= n_oentry_valid;
            r_oaccepted    <= n_oaccepted;
            r_ooverflow    <= n_ooverflow;
            r_ocount       <= n_ocount;
            r_omin         <= n_omin;
            r_olast        <= n_olast;
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.entry_value = r_oentry_value;
    assign o_out.entry_valid = r_oentry_valid;
    assign o_out.accepted    = r_oaccepted;
    assign o_out.overflow    = r_ooverflow;
    assign o_out.entry_count = r_ocount;
    assign o_out.minimum     = r_omin;
    assign o_out.last        = r_olast;

endmodule

@@ sv/msss_cell.sv @@
// One cell of the sorted row: holds a single stored value.
// Depends on msss_pkg for the cell operation codes.
module msss_cell import msss_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int CNT_W       = $clog2(CAPACITY_DEF + 1),
    parameter int IDX         = 0
) (
    input  logic                          i_clk,
    input  t_cell_op                      i_op,
    input  logic [CNT_W-1:0]              i_count,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic signed [SAMPLE_BITS-1:0] i_left_value,
    input  logic                          i_left_ge,
    input  logic signed [SAMPLE_BITS-1:0] i_right_value,
    input  logic signed [SAMPLE_BITS-1:0] i_head_value,
    output logic signed [SAMPLE_BITS-1:0] o_value,
    output logic                          o_ge
);

    logic signed [SAMPLE_BITS-1:0] r_value;
    logic signed [SAMPLE_BITS-1:0] n_value;
    logic                          w_occupied;
    logic                          w_tail;

    // Occupancy and tail position follow from the entry count.
    assign w_occupied = CNT_W'(IDX) < i_count;
    assign w_tail     = i_count == CNT_W'(IDX + 1);

    // A free cell or one holding a value not below the sample marks the
    // insertion point; equal entries therefore move up behind the new one.
    assign o_ge = !w_occupied || (r_value >= i_sample);

    // Next value: shift up on insert, rotate towards the head on readout.
    always_comb begin
        n_value = r_value;
        case (i_op)
            CELL_INSERT: begin
                if (i_left_ge) begin
                    n_value = i_left_value;
                end else if (o_ge) begin
                    n_value = i_sample;
                end
            end
            CELL_ROTATE: begin
                n_value = w_tail ? i_head_value : i_right_value;
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

@@ sv/msss_checker.sv @@
// Port-level checks for the magnitude rise sorted store, and their bind.
// Depends on msss_pkg and on the top level magnitude_rise_sorted_store_core.
module msss_checker import msss_pkg::*; #(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_valid,
    input logic                                 i_ready,
    input logic signed [SAMPLE_BITS-1:0]        i_entry_value,
    input logic                                 i_entry_valid,
    input logic                                 i_accepted,
    input logic                                 i_overflow,
    input logic [$clog2(CAPACITY + 1)-1:0]      i_entry_count,
    input logic signed [SAMPLE_BITS-1:0]        i_minimum,
    input logic                                 i_last
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // A waiting result keeps its payload until taken.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_entry_value) && $stable(i_last)
        && $stable(i_entry_count))
        else $error("stalled result changed");

    // A readout entry never reports an insertion or an overflow.
    a_read_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_entry_valid |-> !i_accepted && !i_overflow)
        else $error("readout entry carries sample flags");

    // The count stays within capacity and an empty store shows a zero minimum.
    a_count_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_entry_count <= CNT_W'(CAPACITY))
        && ((i_entry_count != '0) || (i_minimum == '0)))
        else $error("count beyond capacity or non-zero minimum when empty");

    // A readout continues with the next entry at once and the same count.
    a_read_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready && i_entry_valid && !i_last |=> i_valid && i_entry_valid
        && (i_entry_count == $past(i_entry_count)))
        else $error("readout interrupted");

endmodule

bind magnitude_rise_sorted_store_core msss_checker #(
    .CAPACITY    (CAPACITY),
    .SAMPLE_BITS (SAMPLE_BITS)
) u_msss_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_out.valid),
    .i_ready       (o_out.ready),
    .i_entry_value (o_out.entry_value),
    .i_entry_valid (o_out.entry_valid),
    .i_accepted    (o_out.accepted),
    .i_overflow    (o_out.overflow),
    .i_entry_count (o_out.entry_count),
    .i_minimum     (o_out.minimum),
    .i_last        (o_out.last)
);

@@ tb/msss_store_checker.sv @@
// Checker for the magnitude rise sorted store: watches both channels, predicts every result.
// Depends on msss_pkg and on the msss_in_if and msss_out_if channel interfaces.
module msss_store_checker import msss_pkg::*; #(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    msss_in_if   i_in_mon,
    msss_out_if  i_out_mon,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int COUNT_BITS = $clog2(CAPACITY + 1);

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef struct {
        t_sample               entry_value;
        logic                  entry_valid;
        logic                  accepted;
        logic                  overflow;
        logic [COUNT_BITS-1:0] entry_count;
        t_sample               minimum;
        logic                  last;
    } t_store_result;

    // Predicted contents of the store, kept in ascending order.
    t_sample                sorted_entries[$];
    t_sample                least_entry;
    logic [SAMPLE_BITS-1:0] prev_magnitude;
    logic                   have_prev;

    // Results predicted but not yet seen on the output channel, oldest first.
    t_store_result expected_results[$];
    int            fail_total = 0;

    // Queues one result; count and minimum always reflect the store after the step.
    function automatic void queue_result(t_sample value, logic valid, logic acc, logic ovf,
                                         logic last);
        t_store_result r;
        r.entry_value = value;
        r.entry_valid = valid;
        r.accepted    = acc;
        r.overflow    = ovf;
        r.entry_count = COUNT_BITS'(sorted_entries.size());
        r.minimum     = (sorted_entries.size() == 0) ? '0 : least_entry;
        r.last        = last;
        expected_results.push_back(r);
    endfunction

    // Empties the store and forgets the previous sample, as after reset.
    function automatic void clear_store();
        sorted_entries.delete();
        least_entry    = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        prev_magnitude = '0;
        have_prev      = 1'b0;
    endfunction

    // Applies one accepted input transaction to the predicted store.
    function automatic void predict_store_step(t_mode mode, t_sample sample);
        logic [SAMPLE_BITS-1:0] magnitude;
        int                     pos;
        logic                   acc;
        logic                   ovf;
        acc = 1'b0;
        ovf = 1'b0;
        case (mode)
            MODE_SAMPLE: begin
                // The most negative sample keeps its full magnitude as an unsigned value.
                magnitude = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
                if (have_prev && magnitude > prev_magnitude) begin
                    if (sorted_entries.size() < CAPACITY) begin
                        // A new value goes in front of any equal entries.
                        pos = 0;
                        while (pos < sorted_entries.size() && sorted_entries[pos] < sample)
                            pos++;
                        sorted_entries.insert(pos, sample);
                        if (sample < least_entry)
                            least_entry = sample;
                        acc = 1'b1;
                    end else begin
                        ovf = 1'b1;
                    end
                end
                prev_magnitude = magnitude;
                have_prev      = 1'b1;
                queue_result('0, 1'b0, acc, ovf, 1'b1);
            end
            MODE_CLEAR: begin
                clear_store();
                queue_result('0, 1'b0, 1'b0, 1'b0, 1'b1);
            end
            MODE_READ: begin
                // An empty store still answers with one invalid entry.
                if (sorted_entries.size() == 0) begin
                    queue_result('0, 1'b0, 1'b0, 1'b0, 1'b1);
                end else begin
                    foreach (sorted_entries[i])
                        queue_result(sorted_entries[i], 1'b1, 1'b0, 1'b0,
                                     i == sorted_entries.size() - 1);
                end
            end
            default: begin
                // The unused mode leaves the state alone and reports status only.
                queue_result('0, 1'b0, 1'b0, 1'b0, 1'b1);
            end
        endcase
    endfunction

    // Reports one field that differs from its prediction.
    function automatic int field_differs(string name, logic signed [63:0] want,
                                         logic signed [63:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Predict on each input transaction, then compare each output transaction.
    always @(posedge i_clk) begin : watch
        t_store_result want;
        int            bad;
        if (!i_rst_n) begin
            clear_store();
            expected_results.delete();
        end else begin
            if (i_in_mon.valid && i_in_mon.ready)
                predict_store_step(t_mode'(i_in_mon.mode), i_in_mon.sample);
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing expected, expected none, got value %0d",
                             $time, i_out_mon.entry_value);
                    fail_total++;
                end else begin
                    want = expected_results.pop_front();
                    bad  = 0;
                    bad += field_differs("entry_value", want.entry_value,
                                         i_out_mon.entry_value);
                    bad += field_differs("entry_valid", want.entry_valid,
                                         i_out_mon.entry_valid);
                    bad += field_differs("accepted", want.accepted, i_out_mon.accepted);
                    bad += field_differs("overflow", want.overflow, i_out_mon.overflow);
                    bad += field_differs("entry_count", want.entry_count,
                                         i_out_mon.entry_count);
                    bad += field_differs("minimum", want.minimum, i_out_mon.minimum);
                    bad += field_differs("last", want.last, i_out_mon.last);
                    if (bad != 0)
                        fail_total++;
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_results.size();
    end

endmodule

@@ tb/tb.sv @@
// Testbench top for the magnitude rise sorted store: clock, reset, stimulus and verdict.
// Depends on msss_pkg, the channel interfaces, the core and msss_store_checker.
module tb;
    import msss_pkg::*;

    localparam int SB              = SAMPLE_BITS_DEF;
    localparam int CAP             = CAPACITY_DEF;
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int ITEMS_PER_PHASE = 105;
    localparam int LONG_HOLD       = 300;

    typedef logic signed [SB-1:0] t_sample;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int fail_count;
    int pending;
    int cycle_count    = 0;
    int items_sent     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    bit long_hold_go   = 1'b0;
    bit long_hold_done = 1'b0;

    msss_in_if  #(.SAMPLE_BITS(SB)) in_ch ();
    msss_out_if #(.SAMPLE_BITS(SB), .COUNT_BITS($clog2(CAP + 1))) out_ch ();

    magnitude_rise_sorted_store_core #(
        .CAPACITY   (CAP),
        .SAMPLE_BITS(SB)
    ) dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    msss_store_checker #(
        .CAPACITY   (CAP),
        .SAMPLE_BITS(SB)
    ) store_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_mon    (in_ch),
        .i_out_mon   (out_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // Clock with a period of 8 time units.
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Guard against a hung run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Result receiver: random stalls, plus one long hold-off to fill the block up.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else if (long_hold_go && !long_hold_done) begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD - 1;
                out_ch.ready  <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Offers one input transaction and waits until it is taken.
    task automatic offer(t_mode mode, t_sample sample);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.mode   <= mode;
        in_ch.sample <= sample;
        do @(posedge clk); while (!in_ch.ready);
        items_sent++;
    endtask

    // Signed sample of a given magnitude; the full magnitude only exists as a negative value.
    function automatic t_sample from_magnitude(int mag, bit neg);
        return (neg || mag >= 32768) ? t_sample'(-mag) : t_sample'(mag);
    endfunction

    // Samples of rising magnitude with random signs, so that most of them get stored.
    task automatic rising_run(int len, int base, int max_step);
        int mag;
        mag = base;
        repeat (len) begin
            offer(MODE_SAMPLE, from_magnitude(mag, $urandom_range(1)));
            mag += $urandom_range(1, max_step);
            if (mag > 32768)
                mag = 32768;
        end
    endtask

    // Stimulus: directed cases, then three random phases with different idling.
    initial begin
        int r;
        int target;
        in_ch.valid  = 1'b0;
        in_ch.mode   = MODE_SAMPLE;
        in_ch.sample = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Empty readout, unused mode, and extremes of the sample range.
        offer(MODE_READ, '0);
        offer(MODE_NONE, t_sample'(16'h5a5a));
        offer(MODE_SAMPLE, t_sample'(-32768));
        offer(MODE_SAMPLE, t_sample'(32767));
        offer(MODE_SAMPLE, '0);
        offer(MODE_SAMPLE, t_sample'(1));
        offer(MODE_SAMPLE, t_sample'(-32768));
        offer(MODE_SAMPLE, t_sample'(32767));
        offer(MODE_SAMPLE, '0);
        offer(MODE_SAMPLE, t_sample'(32767));
        // Equal magnitude does not qualify; an equal value does get stored twice.
        offer(MODE_SAMPLE, t_sample'(-1));
        offer(MODE_SAMPLE, t_sample'(1));
        offer(MODE_SAMPLE, t_sample'(-2));
        offer(MODE_SAMPLE, '0);
        offer(MODE_SAMPLE, t_sample'(1));
        offer(MODE_NONE, t_sample'(-32768));
        offer(MODE_READ, t_sample'(16'ha5a5));
        // The first sample after a clear only records its magnitude.
        offer(MODE_CLEAR, t_sample'(-1));
        offer(MODE_SAMPLE, t_sample'(5));
        offer(MODE_SAMPLE, t_sample'(6));
        offer(MODE_READ, '0);
        offer(MODE_CLEAR, '0);
        offer(MODE_READ, '0);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 9;
                    recv_stall_pct = 58;
                end
                1: begin
                    send_idle_pct  = 58;
                    recv_stall_pct = 9;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    long_hold_go   = 1'b1;
                end
            endcase
            target = items_sent + ITEMS_PER_PHASE;

            // Fill the store past capacity, then read all of it back.
            offer(MODE_CLEAR, t_sample'($urandom));
            rising_run(CAP + 4, $urandom_range(0, 50), 400);
            offer(MODE_READ, t_sample'($urandom));

            while (items_sent < target) begin
                r = $urandom_range(99);
                if (r < 45) begin
                    rising_run($urandom_range(2, 10), $urandom_range(0, 20000), 2000);
                end else if (r < 60) begin
                    // Small values around zero give many equal entries.
                    repeat ($urandom_range(3, 8))
                        offer(MODE_SAMPLE, t_sample'(int'($urandom_range(16)) - 8));
                end else if (r < 78) begin
                    offer(MODE_SAMPLE, t_sample'($urandom));
                end else if (r < 88) begin
                    offer(MODE_READ, t_sample'($urandom));
                end else if (r < 93) begin
                    offer(MODE_NONE, t_sample'($urandom));
                end else if (r < 96) begin
                    offer(MODE_CLEAR, t_sample'($urandom));
                end else begin
                    case ($urandom_range(3))
                        0:       offer(MODE_SAMPLE, t_sample'(-32768));
                        1:       offer(MODE_SAMPLE, t_sample'(32767));
                        2:       offer(MODE_SAMPLE, '1);
                        default: offer(MODE_SAMPLE, '0);
                    endcase
                end
            end
        end

        @(negedge clk);
        in_ch.valid <= 1'b0;

        // Drain the outstanding results, then allow a few spare cycles.
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
